[rtl/sbs_pkg.sv]
// Shared types and constants for the sorted-table binary search block.
// Depends on nothing; the channel interfaces and the top level import it.
`default_nettype none

package sbs_pkg;

  // Table geometry
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DATA_W = 32;

  // Width of the entry count register (holds 0 to DEPTH and more)
  localparam int CNT_W = 11;

  // Signed search index: holds -1 up to twice DEPTH for midpoint sums
  localparam int IDX_W = ADDR_W + 3;

  // Position field width on the result channel
  localparam int POS_W = 10;

  typedef logic signed [IDX_W-1:0]  idx_t;
  typedef logic        [ADDR_W-1:0] addr_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic        [CNT_W-1:0]  cnt_t;
  typedef logic        [POS_W-1:0]  pos_t;
  typedef logic        [9:0]        slot_t;

  // Operation codes carried by a request
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_EXACT = 2'd1,
    OP_LAST  = 2'd2,
    OP_FIRST = 2'd3
  } op_t;

endpackage

`default_nettype wire

[rtl/sbs_channels.sv]
// Valid/ready channel interfaces: request, response and configuration.
// Depends on sbs_pkg for the payload types.
`default_nettype none

interface sbs_req_if;
  logic           valid;
  logic           ready;
  sbs_pkg::op_t   op;
  sbs_pkg::slot_t slot;
  sbs_pkg::data_t value;

  modport source (output valid, output op, output slot, output value, input ready);
  modport sink   (input valid, input op, input slot, input value, output ready);
endinterface

interface sbs_rsp_if;
  logic          valid;
  logic          ready;
  logic          found;
  sbs_pkg::pos_t position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

interface sbs_cfg_if;
  logic          valid;
  logic          ready;
  sbs_pkg::cnt_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/sorted_table_binary_search.sv]
// Top level of the sorted-table binary search block: table memory, search
// sequencer and response register. Depends on sbs_pkg and sbs_channels.
//
// A load request writes one table entry. A search request (exact key, last
// one, first one) runs over the first entry_count entries (saturated to the
// table depth) and probes one entry per cycle: the single read port of the
// table memory, with its registered read data, is the loop, each compare
// choosing the next probe address. A search makes at most about
// log2(entry_count)+1 probes (11 for a full 1024-entry table) and then hands
// the result to the response register, directly or through a hold state.
// A new request is taken once the previous result is in the response
// register, even while that response still waits on the output. The
// configuration channel is always ready and should be written only while
// no search is running.
`default_nettype none

module sorted_table_binary_search (
  input  wire        clk,
  input  wire        rst,
  sbs_cfg_if.sink    cfg,
  sbs_req_if.sink    req,
  sbs_rsp_if.source  rsp
);
  import sbs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_HOLD
  } state_t;

  state_t state;
  cnt_t   entry_count;
  op_t    mode;
  data_t  key;
  idx_t   lo;
  idx_t   hi;
  idx_t   mid;
  logic   res_found;
  pos_t   res_pos;
  logic   out_valid;
  logic   out_found;
  pos_t   out_pos;

  // Table memory, undefined until written
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;

  logic   req_xfer;
  logic   rsp_xfer;
  logic   out_free;
  op_t    cur_mode;
  data_t  cur_key;
  data_t  entry;
  idx_t   n_idx;
  idx_t   lo_next;
  idx_t   hi_next;
  idx_t   mid_next;
  idx_t   sum;
  logic   cont;
  logic   hit;
  logic   fin_found;
  pos_t   fin_pos;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_xfer  = req.valid && req.ready;
  assign rsp_xfer  = out_valid && rsp.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid    = out_valid;
  assign rsp.found    = out_found;
  assign rsp.position = out_pos;

  // Saturate the count to the table depth
  assign n_idx = (entry_count > cnt_t'(DEPTH)) ? idx_t'(DEPTH)
                                               : idx_t'({1'b0, entry_count});

  assign cur_mode = (state == S_IDLE) ? req.op : mode;
  assign cur_key  = (state == S_IDLE) ? req.value : key;
  assign entry    = data_t'(rd_data);

  // Bounds for this cycle: initial bounds on a transfer, else narrowed by the probe
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    hit     = 1'b0;
    if (state == S_IDLE) begin
      unique case (cur_mode)
        OP_EXACT: begin
          lo_next = '0;
          hi_next = n_idx - idx_t'(1);
        end
        OP_LAST: begin
          lo_next = -idx_t'(1);
          hi_next = n_idx - idx_t'(1);
        end
        OP_FIRST: begin
          lo_next = '0;
          hi_next = n_idx;
        end
        default: begin
          lo_next = '0;
          hi_next = '0;
        end
      endcase
    end else begin
      unique case (cur_mode)
        OP_EXACT: begin
          hit = (state == S_PROBE) && (entry == cur_key);
          if (entry > cur_key) begin
            hi_next = mid - idx_t'(1);
          end else begin
            lo_next = mid + idx_t'(1);
          end
        end
        OP_LAST: begin
          if (entry == data_t'(1)) begin
            lo_next = mid;
          end else begin
            hi_next = mid - idx_t'(1);
          end
        end
        OP_FIRST: begin
          if (entry == data_t'(1)) begin
            hi_next = mid;
          end else begin
            lo_next = mid + idx_t'(1);
          end
        end
        default: begin
          lo_next = lo;
          hi_next = hi;
        end
      endcase
    end
  end

  // Loop test and next midpoint; every probed sum is non-negative
  always_comb begin
    sum  = lo_next + hi_next;
    cont = 1'b0;
    unique case (cur_mode)
      OP_EXACT: cont = (lo_next <= hi_next);
      OP_LAST: begin
        sum  = lo_next + hi_next + idx_t'(1);
        cont = (lo_next < hi_next);
      end
      OP_FIRST: cont = (lo_next < hi_next);
      default:  cont = 1'b0;
    endcase
    mid_next = sum >>> 1;
  end

  // Result once the probing stops
  always_comb begin
    fin_found = 1'b0;
    if (hit) begin
      fin_found = 1'b1;
    end else begin
      unique case (cur_mode)
        OP_LAST:  fin_found = (lo_next >= idx_t'(0));
        OP_FIRST: fin_found = (lo_next < n_idx);
        default:  fin_found = 1'b0;
      endcase
    end
    if (hit) begin
      fin_pos = mid[POS_W-1:0];
    end else if (fin_found) begin
      fin_pos = lo_next[POS_W-1:0];
    end else begin
      fin_pos = '0;
    end
  end

  // Table write on a load transfer; read the next probe every cycle
  always_ff @(posedge clk) begin
    if (req_xfer && (req.op == OP_LOAD)) begin
      mem[req.slot[ADDR_W-1:0]] <= req.value;
    end
    rd_data <= mem[mid_next[ADDR_W-1:0]];
  end

  // Sequencer, configuration register and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        entry_count <= cfg.data;
      end
      if (rsp_xfer) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_xfer && (req.op != OP_LOAD)) begin
            mode <= req.op;
            key  <= req.value;
            lo   <= lo_next;
            hi   <= hi_next;
            mid  <= mid_next;
            if (cont) begin
              state <= S_PROBE;
            end else begin
              res_found <= fin_found;
              res_pos   <= fin_pos;
              state     <= S_HOLD;
            end
          end
        end
        S_PROBE: begin
          if (hit || !cont) begin
            // Deliver straight away if the output is free, else hold
            if (out_free) begin
              out_valid <= 1'b1;
              out_found <= fin_found;
              out_pos   <= fin_pos;
              state     <= S_IDLE;
            end else begin
              res_found <= fin_found;
              res_pos   <= fin_pos;
              state     <= S_HOLD;
            end
          end else begin
            lo  <= lo_next;
            hi  <= hi_next;
            mid <= mid_next;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_found <= res_found;
            out_pos   <= res_pos;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
